// ===== rtl/core/rpn_pkg.sv =====
// Shared types and constants for the postfix stack evaluator.
// No dependencies; used by every module in rtl/core.
package rpn_pkg;

    localparam int DATA_W      = 32;
    localparam int STACK_DEPTH = 64;
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int DIV_CNT_W   = $clog2(DATA_W + 1);

    localparam int ACT_W       = 3;
    localparam int IN_TDATA_W  = ((ACT_W + DATA_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((DATA_W + 2 + 7) / 8) * 8;

    // action codes
    localparam logic [ACT_W-1:0] ACT_PUSH = 3'd0;
    localparam logic [ACT_W-1:0] ACT_ADD  = 3'd1;
    localparam logic [ACT_W-1:0] ACT_SUB  = 3'd2;
    localparam logic [ACT_W-1:0] ACT_MUL  = 3'd3;
    localparam logic [ACT_W-1:0] ACT_DIV  = 3'd4;

    // status codes
    localparam logic [1:0] ERR_NONE  = 2'd0;
    localparam logic [1:0] ERR_UNDER = 2'd1;
    localparam logic [1:0] ERR_OVER  = 2'd2;
    localparam logic [1:0] ERR_DIV   = 2'd3;

    typedef logic [DATA_W-1:0] data_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        data_t             wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } ram_req_t;

    typedef struct packed {
        logic  start;
        data_t dividend;
        data_t divisor;
    } div_req_t;

endpackage

// ===== rtl/core/rpn_stack_ram.sv =====
// Stack storage: one write port, one read port, registered read data.
// Depends on rpn_pkg.
module rpn_stack_ram
    import rpn_pkg::*;
(
    input  logic     clk,
    input  ram_req_t req,
    output data_t    rdata
);

    data_t mem [STACK_DEPTH];
    data_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
    end

    // read data holds until the next read
    always_ff @(posedge clk)
    begin
        if (req.re)
        begin
            rdata_reg <= mem[req.raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/rpn_div.sv =====
// Signed divider, truncating toward zero, one quotient bit per cycle.
// Depends on rpn_pkg. Caller handles a zero divisor.
module rpn_div
    import rpn_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output logic     done,
    output data_t    quotient
);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    data_t                rem_reg, rem_next;
    data_t                quo_reg, quo_next;
    data_t                den_reg, den_next;
    logic                 neg_reg, neg_next;

    logic [DATA_W:0]      shifted;
    logic [DATA_W:0]      diff;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        neg_next  = neg_reg;
        shifted   = {rem_reg, quo_reg[DATA_W-1]};
        diff      = shifted - {1'b0, den_reg};

        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = DIV_CNT_W'(DATA_W);
            rem_next  = '0;
            quo_next  = req.dividend[DATA_W-1] ? (DATA_W'(0) - req.dividend) : req.dividend;
            den_next  = req.divisor[DATA_W-1] ? (DATA_W'(0) - req.divisor) : req.divisor;
            neg_next  = req.dividend[DATA_W-1] ^ req.divisor[DATA_W-1];
        end
        else if (busy_reg)
        begin
            if (!diff[DATA_W])
            begin
                rem_next = diff[DATA_W-1:0];
                quo_next = {quo_reg[DATA_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[DATA_W-1:0];
                quo_next = {quo_reg[DATA_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
        neg_reg <= neg_next;
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? (DATA_W'(0) - quo_reg) : quo_reg;

endmodule

// ===== rtl/core/rpn_stack_evaluator.sv =====
// Channel  Dir  Payload                                       Handshake
// s_axis   in   tdata: action[2:0], operand_value[34:3]       tvalid/tready, tlast = last
// m_axis   out  tdata: result_value[31:0], status[33:32]      tvalid/tready
//
// Push is accepted and written in S_IDLE. Add, subtract, multiply: two stack reads through the
// registered RAM read port (S_RD_R, S_RD_L), execute (S_ALU), write back (S_PUSH). Divide waits
// in S_DIV for the 32-step bit-serial divider. An item with tlast adds the final
// pop (S_TOP, S_EMIT), plus any wait for m_axis to drain its held result.
// Reset clears the stack count and status; stack RAM contents are not cleared.
// Top level of the postfix evaluator; depends on rpn_pkg, rpn_stack_ram, rpn_div.
module rpn_stack_evaluator
    import rpn_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // action, operand_value
    input  logic                   s_axis_tlast,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata    // result_value, status
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_RD_R = 4'd1;
    localparam logic [3:0] S_RD_L = 4'd2;
    localparam logic [3:0] S_ALU  = 4'd3;
    localparam logic [3:0] S_DIV  = 4'd4;
    localparam logic [3:0] S_PUSH = 4'd5;
    localparam logic [3:0] S_TOP  = 4'd6;
    localparam logic [3:0] S_EMIT = 4'd7;

    logic [3:0]       state_reg, state_next;
    logic [ACT_W-1:0] action_reg, action_next;
    logic             last_reg, last_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [1:0]       flags_reg, flags_next;
    logic             hit_reg, hit_next;
    logic             out_valid_reg, out_valid_next;
    data_t            r_reg, r_next;
    data_t            res_reg, res_next;
    data_t            out_value_reg, out_value_next;
    logic [1:0]       out_status_reg, out_status_next;

    ram_req_t         ram_req;
    data_t            ram_rdata;
    div_req_t         div_req;
    logic             div_done;
    data_t            div_quotient;

    logic             in_fire;
    logic [ACT_W-1:0] in_action;
    data_t            in_value;
    logic             err_set;
    logic [1:0]       err_code;
    logic             emit_go;
    logic [CNT_W-1:0] count_dec;
    data_t            l_val;

    rpn_stack_ram u_ram (
        .clk   (clk),
        .req   (ram_req),
        .rdata (ram_rdata)
    );

    rpn_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .done     (div_done),
        .quotient (div_quotient)
    );

    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign in_action     = s_axis_tdata[ACT_W-1:0];
    assign in_value      = s_axis_tdata[ACT_W +: DATA_W];
    assign count_dec     = count_reg - 1'b1;
    assign l_val         = hit_reg ? ram_rdata : '0;
    assign emit_go       = (state_reg == S_EMIT) && (!out_valid_reg || m_axis_tready);

    always_comb
    begin
        state_next      = state_reg;
        action_next     = action_reg;
        last_next       = last_reg;
        count_next      = count_reg;
        flags_next      = flags_reg;
        hit_next        = hit_reg;
        r_next          = r_reg;
        res_next        = res_reg;
        out_value_next  = out_value_reg;
        out_status_next = out_status_reg;
        out_valid_next  = out_valid_reg;
        err_set         = 1'b0;
        err_code        = ERR_NONE;
        ram_req         = '0;
        div_req         = '0;
        div_req.dividend = l_val;
        div_req.divisor  = r_reg;

        if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    action_next = in_action;
                    last_next   = s_axis_tlast;
                    if (in_action == ACT_PUSH)
                    begin
                        if (count_reg == CNT_W'(STACK_DEPTH))
                        begin
                            err_set  = 1'b1;
                            err_code = ERR_OVER;
                        end
                        else
                        begin
                            ram_req.we    = 1'b1;
                            ram_req.waddr = count_reg[ADDR_W-1:0];
                            ram_req.wdata = in_value;
                            count_next    = count_reg + 1'b1;
                        end
                        state_next = s_axis_tlast ? S_TOP : S_IDLE;
                    end
                    else if (in_action inside {[ACT_ADD:ACT_DIV]})
                    begin
                        state_next = S_RD_R;
                    end
                    else
                    begin
                        // unused codes leave the stack alone
                        state_next = s_axis_tlast ? S_TOP : S_IDLE;
                    end
                end
            end

            S_RD_R, S_RD_L, S_TOP:
            begin
                if (state_reg == S_RD_L)
                begin
                    r_next = hit_reg ? ram_rdata : '0;
                end
                if (count_reg != '0)
                begin
                    ram_req.re    = 1'b1;
                    ram_req.raddr = count_dec[ADDR_W-1:0];
                    count_next    = count_dec;
                    hit_next      = 1'b1;
                end
                else
                begin
                    hit_next = 1'b0;
                    err_set  = 1'b1;
                    err_code = ERR_UNDER;
                end
                case (state_reg)
                    S_RD_R:  state_next = S_RD_L;
                    S_RD_L:  state_next = S_ALU;
                    default: state_next = S_EMIT;
                endcase
            end

            S_ALU:
            begin
                state_next = S_PUSH;
                case (action_reg)
                    ACT_ADD: res_next = l_val + r_reg;
                    ACT_SUB: res_next = l_val - r_reg;
                    ACT_MUL: res_next = DATA_W'(l_val * r_reg);
                    ACT_DIV:
                    begin
                        if (r_reg == '0)
                        begin
                            res_next = '0;
                            err_set  = 1'b1;
                            err_code = ERR_DIV;
                        end
                        else
                        begin
                            div_req.start = 1'b1;
                            state_next    = S_DIV;
                        end
                    end
                    default: res_next = '0;
                endcase
            end

            S_DIV:
            begin
                if (div_done)
                begin
                    res_next   = div_quotient;
                    state_next = S_PUSH;
                end
            end

            S_PUSH:
            begin
                // two pops came first, so the stack has room
                if (count_reg == CNT_W'(STACK_DEPTH))
                begin
                    err_set  = 1'b1;
                    err_code = ERR_OVER;
                end
                else
                begin
                    ram_req.we    = 1'b1;
                    ram_req.waddr = count_reg[ADDR_W-1:0];
                    ram_req.wdata = res_reg;
                    count_next    = count_reg + 1'b1;
                end
                state_next = last_reg ? S_TOP : S_IDLE;
            end

            S_EMIT:
            begin
                if (emit_go)
                begin
                    out_value_next  = l_val;
                    out_status_next = flags_reg;
                    out_valid_next  = 1'b1;
                    count_next      = '0;
                    flags_next      = ERR_NONE;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // first error of the expression sticks
        if (err_set && (flags_reg == ERR_NONE))
        begin
            flags_next = err_code;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            flags_reg     <= ERR_NONE;
            hit_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            flags_reg     <= flags_next;
            hit_reg       <= hit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        action_reg     <= action_next;
        last_reg       <= last_next;
        r_reg          <= r_next;
        res_reg        <= res_next;
        out_value_reg  <= out_value_next;
        out_status_reg <= out_status_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_TDATA_W - DATA_W - 2){1'b0}}, out_status_reg, out_value_reg};

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(STACK_DEPTH))
        else $error("stack count beyond depth");

    a_write_room: assert property (@(posedge clk) disable iff (!rst_n)
        ram_req.we |-> (count_reg < CNT_W'(STACK_DEPTH)))
        else $error("stack write with full stack");

    a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_DIV))
        else $error("divider finished outside divide wait");

    a_emit_clears: assert property (@(posedge clk) disable iff (!rst_n)
        emit_go |=> (m_axis_tvalid && (count_reg == '0) && (flags_reg == ERR_NONE)))
        else $error("result emit did not clear stack state");
`endif

endmodule
